[hdl/wsp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_pkg
// shared types and constants of the world to screen projection core
// ----------------------------------------------------------------------------
package wsp_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int IDX_W         = 5;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int VP_W          = 14;

  localparam logic [CFG_IDX_W-1:0] REG_VP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_OFF = 2'd2;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_PROJECT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAT,     // matrix product, 64 mac steps
    ST_MAT_WR,
    ST_XF,      // point transform, 16 mac steps
    ST_XF_WR,
    ST_XF_FL,   // last clip coordinate lands
    ST_CHKW,
    ST_DIV,     // serial divide, three quotients
    ST_SCR,     // screen map, two multiplies
    ST_OUT
  } wsp_state_t;

  typedef struct packed {
    logic       clr_acc;
    logic       mac_mat;
    logic       mac_xf;
    logic       wr_m;
    logic       wr_c;
    logic       div_start;
    logic       div_step;
    logic       scr_step;
    logic       load_out;
    logic [5:0] cnt;
  } wsp_cmd_t;

  typedef struct packed {
    logic w_zero;
    logic div_done;
  } wsp_sts_t;

endpackage : wsp_pkg
`default_nettype wire

[hdl/world_to_screen_projection_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// world_to_screen_projection_core
// perspective projection and viewport map of world points, Q fixed point
// ----------------------------------------------------------------------------
// channel  | dir | tdata (low bit up)                        | tuser
// in_      | in  | entry_index, entry_value, pos_x/y/z       | mode
// out_     | out | screen_x, screen_y                        | off_screen
// cfg_     | in  | wr_en, index, data                        | -
// a load beat gives no result and leaves the core ready for the next beat
// a project beat keeps the core busy until its result is loaded out (the
// divider and screen map are skipped when w is zero): the shared multiplier
// walks 64 matrix products and 16 transform products, then a bit-serial
// divider forms three quotients one bit a cycle
// out_tready low holds the finished result; a later result waits for it
// reset clears control, config and output valid; datapath and matrix store are not cleared
// ----------------------------------------------------------------------------
module world_to_screen_projection_core
  import wsp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [135:0]          in_tdata,  // entry_index, entry_value, pos_x, pos_y, pos_z
  input  wire logic                  in_tuser,  // mode
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [63:0]                out_tdata, // screen_x, screen_y
  output logic                       out_tuser, // off_screen
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [VP_W-1:0]    vp_w_r, vp_h_r;
  logic signed [31:0] hoff_r;
  logic               out_v_r;
  logic               busy;
  logic               acc_in, start, ld_en;
  wsp_cmd_t           cmd;
  wsp_sts_t           sts;
  logic signed [31:0] sx, sy;
  logic               offs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_w_r <= VP_W'(1280);
      vp_h_r <= VP_W'(720);
      hoff_r <= 32'sd32768;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_VP_WIDTH:   vp_w_r <= cfg_data[VP_W-1:0];
        REG_VP_HEIGHT:  vp_h_r <= cfg_data[VP_W-1:0];
        REG_HEIGHT_OFF: hoff_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = !busy;
  assign acc_in    = in_tvalid && in_tready;
  assign start     = acc_in && (in_tuser == MODE_PROJECT);
  assign ld_en     = acc_in && (in_tuser == MODE_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (cmd.load_out) out_v_r <= 1'b1;
    else if (out_tready) out_v_r <= 1'b0;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {sy, sx};
  assign out_tuser  = offs;

  wsp_ctrl u_ctrl (
    .clk, .rst_n, .start, .out_busy(out_v_r && !out_tready),
    .sts, .busy, .cmd
  );

  wsp_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .ld_en,
    .ld_idx(in_tdata[4:0]), .ld_val(in_tdata[36:5]), .start,
    .pos_x(in_tdata[68:37]), .pos_y(in_tdata[100:69]), .pos_z(in_tdata[132:101]),
    .vp_w(vp_w_r), .vp_h(vp_h_r), .hoff(hoff_r),
    .cmd, .sts, .sx, .sy, .offs
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_tready)
    else $error("beat taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(busy))
    else $error("result without beat");
`endif

endmodule : world_to_screen_projection_core
`default_nettype wire

[hdl/wsp_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_ctrl
// sequencer: walks matrix product, transform and, unless w is zero, division and screen map
// ----------------------------------------------------------------------------
module wsp_ctrl
  import wsp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire logic     out_busy,
  input  wsp_sts_t      sts,
  output logic          busy,
  output wsp_cmd_t      cmd
);

  wsp_state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) state_nxt = ST_MAT;
      end
      ST_MAT: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r[1:0] == 2'd3) state_nxt = ST_MAT_WR;
      end
      ST_MAT_WR: state_nxt = (cnt_r == 6'd0) ? ST_XF : ST_MAT;
      ST_XF: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r[1:0] == 2'd3) state_nxt = ST_XF_WR;
      end
      ST_XF_WR: state_nxt = (cnt_r[3:0] == 4'd0) ? ST_XF_FL : ST_XF;
      ST_XF_FL: state_nxt = ST_CHKW;
      ST_CHKW: begin
        cnt_nxt = '0;
        state_nxt = sts.w_zero ? ST_OUT : ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = '0;
        if (sts.div_done) state_nxt = ST_SCR;
      end
      ST_SCR: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd2) state_nxt = ST_OUT;
      end
      ST_OUT: if (!out_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.cnt = cnt_r;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:   cmd.clr_acc = 1'b1;
      ST_MAT:    cmd.mac_mat = 1'b1;
      ST_MAT_WR: begin cmd.wr_m = 1'b1; cmd.clr_acc = 1'b1; end
      ST_XF:     cmd.mac_xf = 1'b1;
      ST_XF_WR:  begin cmd.wr_c = 1'b1; cmd.clr_acc = 1'b1; end
      ST_XF_FL:  cmd.clr_acc = 1'b0;
      ST_CHKW:   cmd.div_start = !sts.w_zero;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_SCR:    cmd.scr_step = 1'b1;
      ST_OUT:    cmd.load_out = !out_busy;
      default:   cmd = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> state_r == ST_MAT)
    else $error("start not taken");
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts.div_done) |=> state_r == ST_SCR)
    else $error("divide end missed");
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> state_r == ST_IDLE)
    else $error("result loaded twice");
`endif

endmodule : wsp_ctrl
`default_nettype wire

[hdl/wsp_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wsp_dp
// datapath: matrix memory, shared multiplier/accumulator, screen map, serial divider
// ----------------------------------------------------------------------------
module wsp_dp
  import wsp_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
)(
  input  wire logic               clk,
  input  wire logic               ld_en,
  input  wire logic [IDX_W-1:0]   ld_idx,
  input  wire logic signed [31:0] ld_val,
  input  wire logic               start,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic [VP_W-1:0]    vp_w,
  input  wire logic [VP_W-1:0]    vp_h,
  input  wire logic signed [31:0] hoff,
  input  wsp_cmd_t                cmd,
  output wsp_sts_t                sts,
  output logic signed [31:0]      sx,
  output logic signed [31:0]      sy,
  output logic                    offs
);

  localparam logic signed [63:0] ONE   = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] FAR64 = 64'sd999 <<< FRAC_BITS;
  localparam logic signed [31:0] FAR   = (FAR64 > 64'sd2147483647) ?
                                         32'sh7fffffff : FAR64[31:0];
  localparam int DW = 32 + FRAC_BITS;   // dividend bits
  localparam int DCW = $clog2(DW + 1);

  function automatic logic signed [31:0] sat(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // matrix memory, one write port and two registered read ports
  logic signed [31:0] mem [32];
  logic signed [31:0] m_r [16];
  logic signed [31:0] p_r [4];
  logic signed [31:0] c_r [4];
  logic signed [31:0] rd_r;
  logic signed [31:0] opa_r, opb_r;
  logic               mvalid_r;
  logic [IDX_W-1:0]   ra;
  logic signed [63:0] prod_r;
  logic               pvalid_r;
  logic signed [65:0] acc_r;
  logic [5:0]         cnt_d1_r, cnt_d2_r;

  // mac pipeline in mat mode: cnt = {i,j? } encoded as i*16+j*4+k
  logic [1:0] mi, mj, mk;
  assign mi = cmd.cnt[5:4];
  assign mj = cmd.cnt[3:2];
  assign mk = cmd.cnt[1:0];

  always_comb begin
    ra = {1'b1, mk, mj};
  end

  always_ff @(posedge clk) begin
    if (ld_en) mem[ld_idx] <= ld_val;
    if (start) begin
      p_r[0] <= pos_x;
      p_r[1] <= sat(66'(pos_y) + 66'(hoff));
      p_r[2] <= pos_z;
      p_r[3] <= ONE[31:0];
    end
  end

  // pipelined mac: rather than reading V and P combinationally, each step
  // reads the view entry from mem via a second registered port
  logic signed [31:0] va_r;
  always_ff @(posedge clk) begin
    rd_r <= mem[ra];
    va_r <= mem[{1'b0, mi, mk}];
  end

  // staging: a step issues reads, then multiplies, then accumulates; the
  // wr states do not wait for this, so results are stored on the fly below
  logic issue_r, xf1_r;
  logic signed [31:0] xa, xb;
  always_comb begin
    xa = p_r[cmd.cnt[1:0]];
    xb = m_r[{cmd.cnt[1:0], cmd.cnt[3:2]}];
  end

  always_ff @(posedge clk) begin
    issue_r  <= cmd.mac_mat | cmd.mac_xf;
    xf1_r    <= cmd.mac_xf;
    cnt_d1_r <= cmd.cnt;
    if (cmd.mac_xf) begin
      opa_r <= xa;
      opb_r <= xb;
    end
    cnt_d2_r <= cnt_d1_r;
    if (issue_r) prod_r <= (xf1_r ? opa_r : va_r) * (xf1_r ? opb_r : rd_r);
    pvalid_r <= issue_r;
    mvalid_r <= xf1_r;
  end

  // the write states come too early for the pipeline, so the sum is taken
  // on the fly: a result is stored when its fourth product lands
  logic signed [65:0] acc_sum;
  assign acc_sum = acc_r + 66'(prod_r >>> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (pvalid_r) begin
      if (cnt_d2_r[1:0] == 2'd3) begin
        acc_r <= '0;
        if (mvalid_r) c_r[cnt_d2_r[3:2]] <= sat(acc_sum);
        else m_r[cnt_d2_r[5:2]] <= sat(acc_sum);
      end else begin
        acc_r <= acc_sum;
      end
    end else if (cmd.clr_acc || cmd.div_start) begin
      acc_r <= '0;
    end
  end

  // the xf steps map cnt = j*4+i, i in low bits
  // serial restoring divide of |c|<<FRAC_BITS by |w|, three coordinates
  logic [DW-1:0]  num_r;
  logic [32:0]    rem_r;
  logic [DW-1:0]  quo_r;
  logic [DCW-1:0] bit_r;
  logic [1:0]     crd_r;
  logic signed [DW+1:0] nq_r [3];
  logic           ddone_r;
  logic [31:0]    wabs;
  logic [32:0]    rtry;

  assign wabs = c_r[3][31] ? 32'(-c_r[3]) : c_r[3];
  assign rtry = {rem_r[31:0], num_r[DW-1]};

  always_ff @(posedge clk) begin
    ddone_r <= 1'b0;
    if (cmd.div_start) begin
      crd_r <= 2'd0;
      bit_r <= '0;
      rem_r <= '0;
      num_r <= {(c_r[0][31] ? 32'(-c_r[0]) : c_r[0]), FRAC_BITS'(0)};
    end else if (cmd.div_step && !ddone_r) begin
      if (rtry >= {1'b0, wabs}) begin
        rem_r <= rtry - {1'b0, wabs};
        quo_r <= {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_r <= rtry;
        quo_r <= {quo_r[DW-2:0], 1'b0};
      end
      num_r <= {num_r[DW-2:0], 1'b0};
      bit_r <= bit_r + DCW'(1);
      if (bit_r == DCW'(DW)) begin
        nq_r[crd_r] <= (c_r[crd_r][31] ^ c_r[3][31]) ?
                       -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
        bit_r <= '0;
        rem_r <= '0;
        crd_r <= crd_r + 2'd1;
        num_r <= {(c_r[crd_r + 2'd1][31] ? 32'(-c_r[crd_r + 2'd1])
                                          : c_r[crd_r + 2'd1]), FRAC_BITS'(0)};
        if (crd_r == 2'd2) ddone_r <= 1'b1;
      end
    end
  end

  assign sts.w_zero   = (c_r[3] == '0);
  assign sts.div_done = ddone_r;

  // screen map: the first step forms the offsets, the next two one multiply each
  logic inbox;
  logic signed [DW+2:0] tx_r, ty_r;
  logic signed [DW+17:0] scx_r, scy_r;
  assign inbox = (nq_r[0] <= ONE) && (nq_r[0] >= -ONE) &&
                 (nq_r[1] <= ONE) && (nq_r[1] >= -ONE) &&
                 (nq_r[2] <= ONE) && (nq_r[2] >= 0);

  always_ff @(posedge clk) begin
    if (cmd.scr_step) begin
      case (cmd.cnt[1:0])
        2'd0: begin
          tx_r <= (DW+3)'(nq_r[0]) + (DW+3)'(ONE);
          ty_r <= (DW+3)'(ONE) - (DW+3)'(nq_r[1]);
        end
        2'd1: scx_r <= tx_r * $signed({1'b0, vp_w});
        2'd2: scy_r <= ty_r * $signed({1'b0, vp_h});
        default: ;
      endcase
    end
  end

  function automatic logic signed [31:0] satw(input logic signed [DW+17:0] v);
    if (v > (DW+18)'(64'sd2147483647)) return 32'sh7fffffff;
    if (v < -(DW+18)'(64'sd2147483648)) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (sts.w_zero || !inbox) begin
        sx <= FAR; sy <= FAR; offs <= 1'b1;
      end else begin
        sx <= satw(scx_r >>> 1); sy <= satw(scy_r >>> 1); offs <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_acc_clear: assert property (@(posedge clk)
    cmd.div_start |=> acc_r == '0)
    else $error("accumulator not cleared");
  a_done_pulse: assert property (@(posedge clk)
    ddone_r |=> !ddone_r)
    else $error("divide done held");
  a_wzero_nodiv: assert property (@(posedge clk)
    (cmd.div_start) |-> !sts.w_zero)
    else $error("divide started on zero w");
`endif

endmodule : wsp_dp
`default_nettype wire
